>>> design/otob_pkg.sv
// shared types and constants for the octant binning block
`timescale 1ns / 1ps
package otob_pkg;

  localparam int COORD_W = 32;
  localparam int EXT_W   = 32;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 49;
  localparam int MEAN_W  = 33;
  localparam int OCT_N   = 8;
  localparam int OCT_W   = 3;

  localparam logic KIND_MASK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;

  // one classified triangle between front and back
  typedef struct packed {
    logic [OCT_N-1:0] mask;
    logic [EXT_W-1:0] ext_x;
    logic [EXT_W-1:0] ext_y;
    logic [EXT_W-1:0] ext_z;
    logic             fin;
  } entry_t;

  // one result word
  typedef struct packed {
    logic              kind;
    logic [OCT_N-1:0]  octant_mask;
    logic [OCT_W-1:0]  octant;
    logic [CNT_W-1:0]  tri_count;
    logic [MEAN_W-1:0] mean_x;
    logic [MEAN_W-1:0] mean_y;
    logic [MEAN_W-1:0] mean_z;
    logic              last;
  } res_t;

endpackage

>>> design/otob_front.sv
// front end: octant mask and per-axis max edge extent of one triangle
`timescale 1ns / 1ps
module otob_front
  import otob_pkg::*;
(
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  input  logic                      final_triangle,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] center_z,
  output entry_t                    entry
);

  function automatic logic [EXT_W-1:0] abs_diff(input logic signed [COORD_W-1:0] p,
                                                input logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    return d[COORD_W] ? EXT_W'(-d) : EXT_W'(d);
  endfunction

  function automatic logic [EXT_W-1:0] max3(input logic [EXT_W-1:0] e0,
                                            input logic [EXT_W-1:0] e1,
                                            input logic [EXT_W-1:0] e2);
    logic [EXT_W-1:0] m;
    m = (e0 > e1) ? e0 : e1;
    return (m > e2) ? m : e2;
  endfunction

  logic [2:0] above_x, above_y, above_z;
  // per octant bit: 0 x, 1 z, 2 y
  logic [2:0] is_const, side;

  always_comb begin
    above_x = {c_x > center_x, b_x > center_x, a_x > center_x};
    above_y = {c_y > center_y, b_y > center_y, a_y > center_y};
    above_z = {c_z > center_z, b_z > center_z, a_z > center_z};
    is_const = {(&above_y) | ~(|above_y), (&above_z) | ~(|above_z),
                (&above_x) | ~(|above_x)};
    side     = {above_y[0], above_z[0], above_x[0]};
    for (int k = 0; k < OCT_N; k++) begin
      entry.mask[k] = &(~is_const | ~(3'(k) ^ side));
    end
    entry.ext_x = max3(abs_diff(a_x, b_x), abs_diff(b_x, c_x), abs_diff(c_x, a_x));
    entry.ext_y = max3(abs_diff(a_y, b_y), abs_diff(b_y, c_y), abs_diff(c_y, a_y));
    entry.ext_z = max3(abs_diff(a_z, b_z), abs_diff(b_z, c_z), abs_diff(c_z, a_z));
    entry.fin   = final_triangle;
  end

endmodule

>>> design/otob_queue.sv
// two-word queue between front and back
`timescale 1ns / 1ps
module otob_queue
  import otob_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd,
  output entry_t rd_data,
  output logic   empty
);

  entry_t     slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

>>> design/otob_div.sv
// restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module otob_div
  import otob_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quotient[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

endmodule

>>> design/otob_back.sv
// back end: octant accumulators, summary sequencer and result register
`timescale 1ns / 1ps
module otob_back
  import otob_pkg::*;
#(
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic   clk,
  input  logic   rst,
  input  entry_t q_data,
  input  logic   q_empty,
  output logic   q_pop,
  output res_t   res,
  output logic   empty,
  input  logic   pop
);

  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_LIM =
    CNT_W'((MAX_TRIANGLES < CNT_MAX) ? MAX_TRIANGLES : CNT_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMIT = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_SOUT = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt   [OCT_N];
  logic [SUM_W-1:0]  sum_x [OCT_N];
  logic [SUM_W-1:0]  sum_y [OCT_N];
  logic [SUM_W-1:0]  sum_z [OCT_N];
  logic [OCT_N-1:0]  cur_mask;
  logic              cur_fin;
  logic [OCT_W-1:0]  oct;
  logic [1:0]        axis;
  logic [MEAN_W-1:0] mean [3];
  logic              out_valid;
  logic              out_free;
  logic              res_load;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_dividend, div_quo;
  logic [MEAN_W-1:0] div_mean;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [EXT_W-1:0] v);
    logic [SUM_W:0] r;
    r = {1'b0, s} + (SUM_W+1)'(v);
    return r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
  endfunction

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign res_load = out_free && ((state == S_EMIT) || (state == S_SOUT));

  always_comb begin
    unique case (axis)
      AXIS_X:  div_dividend = sum_x[oct];
      AXIS_Y:  div_dividend = sum_y[oct];
      default: div_dividend = sum_z[oct];
    endcase
  end

  assign div_start = (state == S_DIV) && (cnt[oct] != '0);
  assign div_mean  = (|div_quo[SUM_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : div_quo[MEAN_W-1:0];

  otob_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt[oct]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // result register holds one word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oct       <= '0;
      axis      <= AXIS_X;
      for (int k = 0; k < OCT_N; k++) begin
        cnt[k]   <= '0;
        sum_x[k] <= '0;
        sum_y[k] <= '0;
        sum_z[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur_mask <= q_data.mask;
            cur_fin  <= q_data.fin;
            for (int k = 0; k < OCT_N; k++) begin
              if (q_data.mask[k]) begin
                if (cnt[k] < CNT_LIM) cnt[k] <= cnt[k] + 1'b1;
                sum_x[k] <= sat_add(sum_x[k], q_data.ext_x);
                sum_y[k] <= sat_add(sum_y[k], q_data.ext_y);
                sum_z[k] <= sat_add(sum_z[k], q_data.ext_z);
              end
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res   <= {KIND_MASK, cur_mask, {OCT_W{1'b0}}, {CNT_W{1'b0}},
                      {MEAN_W{1'b0}}, {MEAN_W{1'b0}}, {MEAN_W{1'b0}}, !cur_fin};
            oct   <= '0;
            axis  <= AXIS_X;
            state <= cur_fin ? S_DIV : S_IDLE;
          end
        end
        S_DIV: begin
          // empty octant reports zero means
          if (cnt[oct] == '0) begin
            mean[0] <= '0;
            mean[1] <= '0;
            mean[2] <= '0;
            state   <= S_SOUT;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            mean[axis] <= div_mean;
            if (axis == AXIS_Z) begin
              state <= S_SOUT;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_DIV;
            end
          end
        end
        S_SOUT: begin
          if (out_free) begin
            res  <= {KIND_SUMMARY, {OCT_N{1'b0}}, oct, cnt[oct], mean[0], mean[1],
                     mean[2], oct == OCT_W'(OCT_N - 1)};
            axis <= AXIS_X;
            if (oct == OCT_W'(OCT_N - 1)) begin
              for (int k = 0; k < OCT_N; k++) begin
                cnt[k]   <= '0;
                sum_x[k] <= '0;
                sum_y[k] <= '0;
                sum_z[k] <= '0;
              end
              state <= S_IDLE;
            end else begin
              oct   <= oct + 1'b1;
              state <= S_DIV;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/octree_triangle_octant_binning.sv
// top level of the triangle octant binning block
`timescale 1ns / 1ps
// Bins triangles (three signed Q16.16 vertices) into the eight child octants of
// a node whose center is set through the write port (index 0 x, 1 y, 2 z).
// Per axis a vertex is "above" when strictly greater than the center; octant
// bits are x = 1, z = 2, y = 4, and every octant the triangle may touch is set
// in a mask word. Each triangle gives one mask word (kind 0). A triangle marked
// final_triangle also gives eight summary words (kind 1), octants 0 to 7, with
// the saturating count and the truncated mean of the per-axis max edge extent;
// empty octants report zero means, and the accumulators clear afterwards.
// Timing: the front classifies a triangle in the accept cycle and parks it in
// a two-word queue; the back takes a queued triangle, and takes the next only
// once its mask word is in the result register. A final triangle then holds
// the back while one shared restoring divider (49 steps per mean) works out
// the means one by one; the input side keeps accepting until the queue fills.
module octree_triangle_octant_binning
  import otob_pkg::*;
#(
  parameter int MAX_TRIANGLES = 65536
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration writes
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [COORD_W-1:0]        cfg_data,
  // triangle words
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  input  logic                      final_triangle,
  // result words
  output logic                      empty,
  input  logic                      pop,
  output logic                      kind,
  output logic [OCT_N-1:0]          octant_mask,
  output logic [OCT_W-1:0]          octant,
  output logic [CNT_W-1:0]          tri_count,
  output logic [MEAN_W-1:0]         mean_x,
  output logic [MEAN_W-1:0]         mean_y,
  output logic [MEAN_W-1:0]         mean_z,
  output logic                      last
);

  logic signed [COORD_W-1:0] center_x, center_y, center_z;
  entry_t front_entry, q_data;
  logic   q_empty, q_pop;
  res_t   res;

  // node center registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_CENTER_X) center_x <= cfg_data;
      if (cfg_addr == REG_CENTER_Y) center_y <= cfg_data;
      if (cfg_addr == REG_CENTER_Z) center_z <= cfg_data;
    end
  end

  // classify in the accept cycle
  otob_front u_front (
    .a_x            (a_x),
    .a_y            (a_y),
    .a_z            (a_z),
    .b_x            (b_x),
    .b_y            (b_y),
    .b_z            (b_z),
    .c_x            (c_x),
    .c_y            (c_y),
    .c_z            (c_z),
    .final_triangle (final_triangle),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .entry          (front_entry)
  );

  // decouples classification from accumulation and summary
  otob_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (front_entry),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // accumulators, divider sequencing and the result register
  otob_back #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign kind        = res.kind;
  assign octant_mask = res.octant_mask;
  assign octant      = res.octant;
  assign tri_count   = res.tri_count;
  assign mean_x      = res.mean_x;
  assign mean_y      = res.mean_y;
  assign mean_z      = res.mean_z;
  assign last        = res.last;

endmodule

>>> dv/tb_octree_triangle_octant_binning.sv
// testbench for the triangle octant binning block
`timescale 1ns / 1ps
module tb_octree_triangle_octant_binning
  import otob_pkg::*;
();

  localparam int TRI_CAP = 65536;
  localparam logic [48:0] SUM_TOP = {49{1'b1}};
  localparam logic [32:0] MEAN_TOP = {33{1'b1}};
  localparam int N_RANDOM = 250;
  // stall limit: a summary keeps the back busy while the divider works out its means
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic signed [COORD_W-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [COORD_W-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [COORD_W-1:0] c_x = '0, c_y = '0, c_z = '0;
  logic final_triangle = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic kind;
  logic [OCT_N-1:0] octant_mask;
  logic [OCT_W-1:0] octant;
  logic [CNT_W-1:0] tri_count;
  logic [MEAN_W-1:0] mean_x, mean_y, mean_z;
  logic last;

  octree_triangle_octant_binning #(.MAX_TRIANGLES(TRI_CAP)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one triangle: vertex coords in order a_x a_y a_z b_x .. c_z
  typedef struct {
    logic signed [31:0] v[9];
    logic fin;
  } tri_t;

  // predictor state
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic [16:0] bin_count[8];
  logic [48:0] ext_sum_x[8], ext_sum_y[8], ext_sum_z[8];

  res_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int summaries_seen = 0;
  int tris_sent = 0;
  int idle_cycles = 0;

  task automatic report(input string what, input res_t got, input res_t want);
    errors++;
    $display("mismatch %s at %0t: got %p want %p", what, $time, got, want);
  endtask

  function automatic logic [31:0] axis_extent(input logic signed [31:0] p, q, r);
    logic signed [32:0] d[3];
    logic [32:0] m;
    d[0] = p - q;
    d[1] = q - r;
    d[2] = r - p;
    m = '0;
    foreach (d[i]) begin
      if (d[i] < 0) d[i] = -d[i];
      if (d[i] > m) m = d[i];
    end
    return m[31:0];
  endfunction

  function automatic logic [48:0] sat_sum(input logic [48:0] s, input logic [31:0] e);
    logic [49:0] r;
    r = s + e;
    return (r > SUM_TOP) ? SUM_TOP : r[48:0];
  endfunction

  function automatic logic [32:0] bin_mean(input logic [48:0] s, input logic [16:0] c);
    logic [48:0] m;
    if (c == 0) return '0;
    m = s / c;
    return (m > MEAN_TOP) ? MEAN_TOP : m[32:0];
  endfunction

  // classify one triangle: which octants, per axis side counts
  function automatic logic [7:0] octant_set(input tri_t t);
    int sx, sy, sz;
    logic [2:0] base, free_bits;
    logic [7:0] m;
    sx = (t.v[0] > ctr_x) + (t.v[3] > ctr_x) + (t.v[6] > ctr_x);
    sy = (t.v[1] > ctr_y) + (t.v[4] > ctr_y) + (t.v[7] > ctr_y);
    sz = (t.v[2] > ctr_z) + (t.v[5] > ctr_z) + (t.v[8] > ctr_z);
    base = {sy == 3, sz == 3, sx == 3};
    free_bits = {sy == 1 || sy == 2, sz == 1 || sz == 2, sx == 1 || sx == 2};
    m = '0;
    for (int s = 0; s < 8; s++)
      if ((s[2:0] & ~free_bits) == 0) m[base | s[2:0]] = 1'b1;
    return m;
  endfunction

  task automatic predict_triangle(input tri_t t);
    logic [7:0] m;
    logic [31:0] ex, ey, ez;
    res_t w;
    m = octant_set(t);
    ex = axis_extent(t.v[0], t.v[3], t.v[6]);
    ey = axis_extent(t.v[1], t.v[4], t.v[7]);
    ez = axis_extent(t.v[2], t.v[5], t.v[8]);
    for (int k = 0; k < 8; k++)
      if (m[k]) begin
        if (bin_count[k] < TRI_CAP) bin_count[k]++;
        ext_sum_x[k] = sat_sum(ext_sum_x[k], ex);
        ext_sum_y[k] = sat_sum(ext_sum_y[k], ey);
        ext_sum_z[k] = sat_sum(ext_sum_z[k], ez);
      end
    w = '0;
    w.kind = KIND_MASK;
    w.octant_mask = m;
    w.last = !t.fin;
    expected_words.insert(expected_words.size(), w);
    if (t.fin) begin
      for (int k = 0; k < 8; k++) begin
        w = '0;
        w.kind = KIND_SUMMARY;
        w.octant = k[2:0];
        w.tri_count = bin_count[k];
        w.mean_x = bin_mean(ext_sum_x[k], bin_count[k]);
        w.mean_y = bin_mean(ext_sum_y[k], bin_count[k]);
        w.mean_z = bin_mean(ext_sum_z[k], bin_count[k]);
        w.last = (k == 7);
        expected_words.insert(expected_words.size(), w);
        bin_count[k] = '0;
        ext_sum_x[k] = '0;
        ext_sum_y[k] = '0;
        ext_sum_z[k] = '0;
      end
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random result side stalls, with stretches of none
  logic pop_free = 1'b0;
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      pop = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      g = pop_free ? 0 : gap_len();
      if (g > 0) begin
        pop = 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && pop && !empty) begin
      got = '{kind, octant_mask, octant, tri_count, mean_x, mean_y, mean_z, last};
      words_seen++;
      if (kind == KIND_SUMMARY) summaries_seen++;
      if (expected_words.size() == 0) report("unexpected word", got, '0);
      else begin
        want = expected_words.pop_front();
        if (got.kind != want.kind) report("kind", got, want);
        if (got.octant_mask != want.octant_mask) report("octant_mask", got, want);
        if (got.octant != want.octant) report("octant", got, want);
        if (got.tri_count != want.tri_count) report("tri_count", got, want);
        if (got.mean_x != want.mean_x) report("mean_x", got, want);
        if (got.mean_y != want.mean_y) report("mean_y", got, want);
        if (got.mean_z != want.mean_z) report("mean_z", got, want);
        if (got.last != want.last) report("last", got, want);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_center(input logic [1:0] idx, input logic signed [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_X: ctr_x = val;
      REG_CENTER_Y: ctr_y = val;
      default: ctr_z = val;
    endcase
  endtask

  // push one triangle and wait for acceptance; push stays up if next is back to back
  task automatic send_triangle(input tri_t t);
    int g;
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <=
      {t.v[0], t.v[1], t.v[2], t.v[3], t.v[4], t.v[5], t.v[6], t.v[7], t.v[8]};
    final_triangle <= t.fin;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_triangle(t);
    tris_sent++;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // wait for the block to drain, then some extra cycles
  task automatic drain();
    int n;
    n = 0;
    push <= 1'b0;
    while (expected_words.size() != 0 && n < 200000) begin
      @(negedge clk);
      n++;
    end
    repeat (40) @(negedge clk);
  endtask

  function automatic tri_t make_tri(input logic signed [31:0] x0, y0, z0, x1, y1, z1,
                                    x2, y2, z2, input logic f);
    tri_t t;
    t.v = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
    t.fin = f;
    return t;
  endfunction

  // random coordinate: near the center, at the extremes, or anywhere
  function automatic logic signed [31:0] rand_coord(input logic signed [31:0] c);
    case ($urandom_range(0, 5))
      0: return c + $signed($urandom_range(0, 8)) - 4;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return c;
      default: return $urandom();
    endcase
  endfunction

  localparam logic signed [31:0] MAXP = 32'sh7fffffff;
  localparam logic signed [31:0] MINN = 32'sh80000000;

  tri_t directed[$];
  res_t first_word;

  initial begin
    tri_t t;
    ctr_x = '0; ctr_y = '0; ctr_z = '0;
    for (int k = 0; k < 8; k++) begin
      bin_count[k] = '0;
      ext_sum_x[k] = '0; ext_sum_y[k] = '0; ext_sum_z[k] = '0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: one triangle per octant, then straddling one, two, three axes
    for (int k = 0; k < 8; k++)
      directed.insert(directed.size(),
                      make_tri(k[0] ? 1 : -1, k[2] ? 1 : -1, k[1] ? 1 : -1,
                               k[0] ? 5 : 0, k[2] ? 5 : 0, k[1] ? 5 : 0,
                               k[0] ? 9 : -9, k[2] ? 9 : -9, k[1] ? 9 : -9, 1'b0));
    directed.insert(directed.size(), make_tri(-1, 1, 1, 1, 1, 1, 2, 2, 2, 1'b0));
    directed.insert(directed.size(), make_tri(-1, -1, 1, 1, 1, 1, 2, 2, 2, 1'b0));
    directed.insert(directed.size(), make_tri(-1, -1, -1, 1, 1, 1, 0, 0, 0, 1'b0));
    // widest and zero extents on every axis
    directed.insert(directed.size(),
                    make_tri(MINN, MINN, MINN, MAXP, MAXP, MAXP, 0, 0, 0, 1'b0));
    directed.insert(directed.size(),
                    make_tri(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 1'b0));
    directed.insert(directed.size(),
                    make_tri(MINN, MAXP, MINN, MAXP, MINN, MAXP, MINN, MAXP, MINN, 1'b1));
    // a summary with only this triangle accumulated: all octants empty except octant 0
    directed.insert(directed.size(), make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));

    // after reset the all-on-center triangle lands in octant 0 alone
    first_word = '0;
    first_word.octant_mask = 8'h01;
    first_word.last = 1'b1;
    t = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    if (octant_set(t) != first_word.octant_mask) report("predictor", '0, first_word);

    foreach (directed[i]) send_triangle(directed[i]);
    drain();

    // random phases under different centers, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_center(REG_CENTER_X, MAXP); write_center(REG_CENTER_Y, MINN);
                 write_center(REG_CENTER_Z, 0); end
        1: begin write_center(REG_CENTER_X, MINN); write_center(REG_CENTER_Y, MAXP);
                 write_center(REG_CENTER_Z, MAXP); end
        2: begin write_center(REG_CENTER_X, 32'sh00010000);
                 write_center(REG_CENTER_Y, -32'sh00008000);
                 write_center(REG_CENTER_Z, MINN); end
        default: begin write_center(REG_CENTER_X, $urandom());
                       write_center(REG_CENTER_Y, $urandom());
                       write_center(REG_CENTER_Z, $urandom()); end
      endcase
      pop_free = (phase == 3);
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        for (int j = 0; j < 9; j++)
          t.v[j] = rand_coord((j % 3 == 0) ? ctr_x : (j % 3 == 1) ? ctr_y : ctr_z);
        t.fin = ($urandom_range(0, 11) == 0) || (i == N_RANDOM / 5 - 1);
        send_triangle(t);
      end
      drain();
    end

    $display("sent %0d triangles; checked %0d result words, %0d of them summaries",
             tris_sent, words_seen, summaries_seen);
    $display("centers swept across both extremes and random values");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d words never arrived", errors, expected_words.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
